// ===== hdl/rgb_gamma_gain_correction_defines.svh =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction assertion macros
// Shared assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_GAMMA_GAIN_CORRECTION_DEFINES_SVH
`define RGB_GAMMA_GAIN_CORRECTION_DEFINES_SVH

// Same-cycle implication.
`define RGG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RGG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rgg_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction package
// Fixed-point constants, register codes and elaboration-time table builders.
// ----------------------------------------------------------------------------
package rgg_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int REG_BITS    = 14;
    localparam int VAL_BITS    = 31;
    localparam int COEF_BITS   = 30;
    localparam int P_BITS      = 43;
    localparam int SHIFT_BITS  = 5;
    localparam int EXP_STAGES  = 16;
    localparam int MAX_SHIFT   = 30;

    localparam logic [REG_BITS-1:0] GAMMA_FLOOR = 14'd410;
    localparam logic [REG_BITS-1:0] GAIN_FLOOR  = 14'd41;
    localparam logic [REG_BITS-1:0] REG_RESET   = 14'd4096;
    localparam logic [VAL_BITS-1:0] ONE_Q30     = 31'h4000_0000;

    typedef enum logic [1:0] {
        REG_GAMMA      = 2'd0,
        REG_RED_GAIN   = 2'd1,
        REG_GREEN_GAIN = 2'd2,
        REG_BLUE_GAIN  = 2'd3
    } cfg_reg_t;

    function automatic longint unsigned rgg_log2_q16(input longint unsigned x);
        longint unsigned t;
        longint unsigned m;
        longint unsigned r;
        int              n;
        t = x;
        n = 0;
        while (t > 1)
        begin
            t = t >> 1;
            n = n + 1;
        end
        m = x << (30 - n);
        r = longint'(n) << 16;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                r = r | (64'd1 << i);
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic longint unsigned rgg_isqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // Factor 2^(-2^-(16-i)) in Q30, used when fraction bit i is set.
    function automatic logic [COEF_BITS-1:0] rgg_exp_coef(input int i);
        longint unsigned c;
        c = 64'd1 << 29;
        for (int j = 15; j >= i; j--)
            c = rgg_isqrt(c << 30);
        return COEF_BITS'(c);
    endfunction

endpackage

// ===== hdl/rgg_stream_if.sv =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction stream interfaces
// Valid/ready channels for input pixel words and corrected level words.
// ----------------------------------------------------------------------------
interface rgg_in_if #(parameter int CODE_BITS = 8);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] red_code;
    logic [CODE_BITS-1:0] green_code;
    logic [CODE_BITS-1:0] blue_code;

    modport source (output valid, output red_code, output green_code, output blue_code,
                    input ready);
    modport sink (input valid, input red_code, input green_code, input blue_code,
                  output ready);
endinterface

interface rgg_out_if #(parameter int LEVEL_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] red_level;
    logic [LEVEL_BITS-1:0] green_level;
    logic [LEVEL_BITS-1:0] blue_level;

    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

// ===== hdl/rgg_div.sv =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction divider
// Pipelined restoring divider, one quotient bit per stage, with a tag bit.
// ----------------------------------------------------------------------------
module rgg_div import rgg_pkg::*;
#(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] in_num,
    input  logic                in_tag,
    input  logic [DEN_BITS-1:0] den,
    output logic                out_valid,
    output logic [NUM_BITS-1:0] out_quo,
    output logic                out_tag
);

    logic                vld_reg [NUM_BITS];
    logic                tag_reg [NUM_BITS];
    logic [DEN_BITS-1:0] rem_reg [NUM_BITS];
    logic [NUM_BITS-1:0] nq_reg  [NUM_BITS];

    for (genvar s = 0; s < NUM_BITS; s++)
    begin : g_stage
        logic                p_vld;
        logic                p_tag;
        logic [DEN_BITS-1:0] p_rem;
        logic [NUM_BITS-1:0] p_nq;
        logic [DEN_BITS:0]   trial;
        logic                ge;
        logic [DEN_BITS-1:0] rem_next;
        logic [NUM_BITS-1:0] nq_next;

        if (s == 0)
        begin : g_first
            assign p_vld = in_valid;
            assign p_tag = in_tag;
            assign p_rem = '0;
            assign p_nq  = in_num;
        end
        else
        begin : g_rest
            assign p_vld = vld_reg[s-1];
            assign p_tag = tag_reg[s-1];
            assign p_rem = rem_reg[s-1];
            assign p_nq  = nq_reg[s-1];
        end

        always_comb
        begin
            trial    = {p_rem, p_nq[NUM_BITS-1]};
            ge       = (trial >= {1'b0, den});
            rem_next = ge ? DEN_BITS'(trial - {1'b0, den}) : DEN_BITS'(trial);
            nq_next  = {p_nq[NUM_BITS-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= p_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[s] <= p_tag;
                rem_reg[s] <= rem_next;
                nq_reg[s]  <= nq_next;
            end
        end
    end

    assign out_valid = vld_reg[NUM_BITS-1];
    assign out_quo   = nq_reg[NUM_BITS-1];
    assign out_tag   = tag_reg[NUM_BITS-1];

endmodule

// ===== hdl/rgg_lane.sv =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction lane
// One color channel: log2 distance lookup, division by gamma, exp2 product
// chain, gain multiply and rounding to an output level.
// ----------------------------------------------------------------------------
module rgg_lane import rgg_pkg::*;
#(
    parameter int CODE_BITS  = 8,
    parameter int LEVEL_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [CODE_BITS-1:0]  code,
    input  logic [REG_BITS-1:0]   gamma,
    input  logic [REG_BITS-1:0]   gain,
    output logic                  out_valid,
    output logic [LEVEL_BITS-1:0] level
);

    localparam int FULL     = 2**CODE_BITS - 1;
    localparam int DEPTH    = 2**CODE_BITS;
    localparam int D_BITS   = $clog2(CODE_BITS) + FRAC_BITS;
    localparam int NUM_BITS = D_BITS + 13;
    localparam int PROD_W   = VAL_BITS + COEF_BITS;
    localparam int GP_W     = VAL_BITS + REG_BITS;
    localparam int SUM_W    = P_BITS + LEVEL_BITS + 1;

    logic [D_BITS-1:0]    dist_tab [DEPTH];
    logic [COEF_BITS-1:0] coef_tab [EXP_STAGES];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_dist
        if (i == 0)
        begin : g_zero
            assign dist_tab[i] = '0;
        end
        else
        begin : g_val
            assign dist_tab[i] = D_BITS'(rgg_log2_q16(FULL) - rgg_log2_q16(i));
        end
    end

    for (genvar i = 0; i < EXP_STAGES; i++)
    begin : g_coef
        assign coef_tab[i] = rgg_exp_coef(i);
    end

    logic                a_vld_reg;
    logic                a_zero_reg;
    logic [NUM_BITS-1:0] a_num_reg;
    logic [NUM_BITS-1:0] a_num_next;

    assign a_num_next = NUM_BITS'({dist_tab[code], 12'b0}) + NUM_BITS'(gamma[REG_BITS-1:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_zero_reg <= (code == '0);
            a_num_reg  <= a_num_next;
        end
    end

    logic                q_vld;
    logic                q_zero;
    logic [NUM_BITS-1:0] q_quo;

    rgg_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (REG_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_vld_reg),
        .in_num    (a_num_reg),
        .in_tag    (a_zero_reg),
        .den       (gamma),
        .out_valid (q_vld),
        .out_quo   (q_quo),
        .out_tag   (q_zero)
    );

    logic                  x_vld_reg   [EXP_STAGES];
    logic                  x_zero_reg  [EXP_STAGES];
    logic [VAL_BITS-1:0]   x_val_reg   [EXP_STAGES];
    logic [FRAC_BITS-1:0]  x_frac_reg  [EXP_STAGES];
    logic [SHIFT_BITS-1:0] x_shift_reg [EXP_STAGES];

    logic q_big;
    assign q_big = (q_quo[NUM_BITS-1:FRAC_BITS] > (NUM_BITS-FRAC_BITS)'(MAX_SHIFT));

    for (genvar j = 0; j < EXP_STAGES; j++)
    begin : g_exp
        logic                  p_vld;
        logic                  p_zero;
        logic [VAL_BITS-1:0]   p_val;
        logic [FRAC_BITS-1:0]  p_frac;
        logic [SHIFT_BITS-1:0] p_shift;
        logic [PROD_W-1:0]     prod;

        if (j == 0)
        begin : g_first
            assign p_vld   = q_vld;
            assign p_zero  = q_zero | q_big;
            assign p_val   = ONE_Q30;
            assign p_frac  = q_quo[FRAC_BITS-1:0];
            assign p_shift = q_quo[FRAC_BITS +: SHIFT_BITS];
        end
        else
        begin : g_rest
            assign p_vld   = x_vld_reg[j-1];
            assign p_zero  = x_zero_reg[j-1];
            assign p_val   = x_val_reg[j-1];
            assign p_frac  = x_frac_reg[j-1];
            assign p_shift = x_shift_reg[j-1];
        end

        assign prod = PROD_W'(p_val) * PROD_W'(coef_tab[EXP_STAGES-1-j]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                x_vld_reg[j] <= 1'b0;
            else if (en)
                x_vld_reg[j] <= p_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_zero_reg[j]  <= p_zero;
                x_frac_reg[j]  <= p_frac;
                x_shift_reg[j] <= p_shift;
                x_val_reg[j]   <= p_frac[EXP_STAGES-1-j] ? prod[30 +: VAL_BITS] : p_val;
            end
        end
    end

    logic                g_vld_reg;
    logic                g_zero_reg;
    logic [P_BITS-1:0]   g_p_reg;
    logic [VAL_BITS-1:0] g_ev;
    logic [GP_W-1:0]     g_prod;
    logic [P_BITS-1:0]   g_p_next;

    always_comb
    begin
        g_ev   = x_val_reg[EXP_STAGES-1] >> x_shift_reg[EXP_STAGES-1];
        g_prod = GP_W'(g_ev) * GP_W'(gain);
        if (g_prod > (GP_W'(1) << 42))
            g_p_next = P_BITS'(1) << 42;
        else
            g_p_next = g_prod[P_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (en)
            g_vld_reg <= x_vld_reg[EXP_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_zero_reg <= x_zero_reg[EXP_STAGES-1];
            g_p_reg    <= g_p_next;
        end
    end

    logic                  l_vld_reg;
    logic [LEVEL_BITS-1:0] l_level_reg;
    logic [SUM_W-1:0]      l_sum;
    logic [LEVEL_BITS-1:0] l_level_next;

    always_comb
    begin
        l_sum        = (SUM_W'(g_p_reg) << LEVEL_BITS) - SUM_W'(g_p_reg) + (SUM_W'(1) << 41);
        l_level_next = g_zero_reg ? '0 : l_sum[42 +: LEVEL_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_vld_reg <= 1'b0;
        else if (en)
            l_vld_reg <= g_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            l_level_reg <= l_level_next;
    end

    assign out_valid = l_vld_reg;
    assign level     = l_level_reg;

endmodule

// ===== hdl/rgb_gamma_gain_correction.sv =====
// ----------------------------------------------------------------------------
// RGB gamma and gain correction
// Three parallel channel lanes apply x^(1/gamma) times gain to an RGB word.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock, unless stalled, and returns one
// level word per pixel, in order. Each lane passes through the input
// register, the restoring divider that resolves one quotient bit per stage,
// the sixteen-stage exp2 multiplier chain and the gain and level registers.
// Each lane pipeline stalls as a whole only while a finished word waits at
// the output and the sink is not ready.
`include "rgb_gamma_gain_correction_defines.svh"

module rgb_gamma_gain_correction import rgg_pkg::*;
#(
    parameter int CODE_BITS  = 8,
    parameter int LEVEL_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    rgg_in_if.sink              pix_in,
    rgg_out_if.source           pix_out,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [REG_BITS-1:0] cfg_data
);

    logic [REG_BITS-1:0] gamma_reg;
    logic [REG_BITS-1:0] red_gain_reg;
    logic [REG_BITS-1:0] green_gain_reg;
    logic [REG_BITS-1:0] blue_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg      <= REG_RESET;
            red_gain_reg   <= REG_RESET;
            green_gain_reg <= REG_RESET;
            blue_gain_reg  <= REG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAMMA:      gamma_reg      <= cfg_data;
                REG_RED_GAIN:   red_gain_reg   <= cfg_data;
                REG_GREEN_GAIN: green_gain_reg <= cfg_data;
                REG_BLUE_GAIN:  blue_gain_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    logic [REG_BITS-1:0] gamma_eff;
    logic [REG_BITS-1:0] red_gain_eff;
    logic [REG_BITS-1:0] green_gain_eff;
    logic [REG_BITS-1:0] blue_gain_eff;

    assign gamma_eff      = (gamma_reg < GAMMA_FLOOR) ? GAMMA_FLOOR : gamma_reg;
    assign red_gain_eff   = (red_gain_reg < GAIN_FLOOR) ? GAIN_FLOOR : red_gain_reg;
    assign green_gain_eff = (green_gain_reg < GAIN_FLOOR) ? GAIN_FLOOR : green_gain_reg;
    assign blue_gain_eff  = (blue_gain_reg < GAIN_FLOOR) ? GAIN_FLOOR : blue_gain_reg;

    logic en;
    logic red_vld;
    logic green_vld;
    logic blue_vld;

    assign en           = !red_vld || pix_out.ready;
    assign pix_in.ready = en;

    rgg_lane #(
        .CODE_BITS  (CODE_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_red (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .code      (pix_in.red_code),
        .gamma     (gamma_eff),
        .gain      (red_gain_eff),
        .out_valid (red_vld),
        .level     (pix_out.red_level)
    );

    rgg_lane #(
        .CODE_BITS  (CODE_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_green (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .code      (pix_in.green_code),
        .gamma     (gamma_eff),
        .gain      (green_gain_eff),
        .out_valid (green_vld),
        .level     (pix_out.green_level)
    );

    rgg_lane #(
        .CODE_BITS  (CODE_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_blue (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .code      (pix_in.blue_code),
        .gamma     (gamma_eff),
        .gain      (blue_gain_eff),
        .out_valid (blue_vld),
        .level     (pix_out.blue_level)
    );

    assign pix_out.valid = red_vld;

    `RGG_ASSERT_IMP(a_lanes_aligned, 1'b1, (red_vld == green_vld) && (red_vld == blue_vld), "lane valid bits disagree")
    `RGG_ASSERT_IMP(a_ready_when_empty, !red_vld, pix_in.ready, "input stalled with an empty output")
    `RGG_ASSERT_IMP(a_gamma_floor, 1'b1, gamma_eff >= GAMMA_FLOOR, "gamma below its floor")
    `RGG_ASSERT_NXT(a_cfg_gamma, cfg_we && (cfg_index == REG_GAMMA), gamma_reg == $past(cfg_data), "gamma write lost")

endmodule
